// File: hw/rtl/swbh_pkg.sv
// Package for the swept box against static box hit core.
// Holds the word types of both channels and the side codes.
// It depends on nothing else.
`timescale 1ns / 1ps

package swbh_pkg;

  localparam int unsigned CW = 35;

  localparam logic [2:0] SIDE_NONE   = 3'd0;
  localparam logic [2:0] SIDE_TOP    = 3'd1;
  localparam logic [2:0] SIDE_BOTTOM = 3'd2;
  localparam logic [2:0] SIDE_LEFT   = 3'd3;
  localparam logic [2:0] SIDE_RIGHT  = 3'd4;

  typedef struct packed {
    logic [30:0]        fixed_half_width;
    logic [30:0]        fixed_half_height;
    logic signed [31:0] fixed_center_x;
    logic signed [31:0] fixed_center_y;
    logic [30:0]        mover_half_width;
    logic [30:0]        mover_half_height;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic [31:0]        best_time_in;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic [2:0]         side;
    logic [31:0]        best_time_out;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
  } out_t;

  typedef struct packed {
    logic               ok_y;
    logic               ok_x;
    logic signed [CW-1:0] face_y;
    logic signed [CW-1:0] face_x;
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] right;
    logic signed [CW-1:0] bottom;
    logic signed [CW-1:0] top;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [31:0]        best;
  } ctx_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] num;
    logic [31:0] den;
    logic [31:0] quo;
  } div_t;

endpackage

// File: hw/rtl/swept_box_vs_static_box_hit_core.sv
// Top level of the swept box against static box hit core.
// Uses the word types and side codes from swbh_pkg.
`timescale 1ns / 1ps

// The core takes one word per cycle while in_stall_o is low and returns one
// result word per input word. The pipeline holds a one bit per stage
// restoring divider of 32 stages for each axis, plus an input register, a
// setup stage, a multiply stage, a crossing stage and the output register.
// A stall at the output while a result is valid holds the whole pipeline.
module swept_box_vs_static_box_hit_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  swbh_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output swbh_pkg::out_t  out_data_o
);

  localparam int unsigned NS = 37;
  localparam int unsigned CW = swbh_pkg::CW;

  function automatic swbh_pkg::div_t div_step(input swbh_pkg::div_t d);
    swbh_pkg::div_t r;
    logic [32:0] t;
    logic        ge;
    r  = d;
    t  = {d.rem, d.num[31]};
    ge = t >= {1'b0, d.den};
    r.rem = ge ? 32'(t - {1'b0, d.den}) : t[31:0];
    r.num = {d.num[30:0], 1'b0};
    r.quo = {d.quo[30:0], ge};
    return r;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [CW-1:0] v);
    logic [31:0] r;
    if (!v[CW-1] && (v[CW-2:31] != '0)) begin
      r = 32'h7FFF_FFFF;
    end else if (v[CW-1] && (v[CW-2:31] != '1)) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic en;
  logic [NS-1:0] vld_q;

  assign en          = !vld_q[NS-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  swbh_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  logic signed [CW-1:0] cx_w, cy_w, sx_w, sy_w, fhw_w, fhh_w, mhw_w, mhh_w;
  logic signed [CW-1:0] top_w, bottom_w, left_w, right_w;
  logic signed [CW-1:0] face_y_w, face_x_w, dist_y_w, dist_x_w;
  logic [CW-1:0]        mag_y_w, mag_x_w;
  logic [31:0]          den_y_w, den_x_w;
  logic                 ovf_y_w, ovf_x_w;
  swbh_pkg::ctx_t       ctx_w;
  swbh_pkg::div_t       dy_w, dx_w;

  always_comb begin
    cx_w  = CW'(in_q.fixed_center_x);
    cy_w  = CW'(in_q.fixed_center_y);
    sx_w  = CW'(in_q.start_x);
    sy_w  = CW'(in_q.start_y);
    fhw_w = $signed({4'd0, in_q.fixed_half_width});
    fhh_w = $signed({4'd0, in_q.fixed_half_height});
    mhw_w = $signed({4'd0, in_q.mover_half_width});
    mhh_w = $signed({4'd0, in_q.mover_half_height});
    top_w    = cy_w + fhh_w + mhh_w;
    bottom_w = cy_w - fhh_w - mhh_w;
    left_w   = cx_w - fhw_w - mhw_w;
    right_w  = cx_w + fhw_w + mhw_w;
    face_y_w = in_q.velocity_y[31] ? top_w : bottom_w;
    face_x_w = in_q.velocity_x[31] ? right_w : left_w;
    dist_y_w = face_y_w - sy_w;
    dist_x_w = face_x_w - sx_w;
    mag_y_w  = dist_y_w[CW-1] ? CW'(-dist_y_w) : dist_y_w;
    mag_x_w  = dist_x_w[CW-1] ? CW'(-dist_x_w) : dist_x_w;
    den_y_w  = in_q.velocity_y[31] ? (~in_q.velocity_y + 32'd1) : in_q.velocity_y;
    den_x_w  = in_q.velocity_x[31] ? (~in_q.velocity_x + 32'd1) : in_q.velocity_x;
    ovf_y_w  = {13'd0, mag_y_w} >= {den_y_w, 16'd0};
    ovf_x_w  = {13'd0, mag_x_w} >= {den_x_w, 16'd0};

    ctx_w.ok_y   = (in_q.velocity_y != '0) && !ovf_y_w &&
                   ((dist_y_w == '0) || (dist_y_w[CW-1] == in_q.velocity_y[31]));
    ctx_w.ok_x   = (in_q.velocity_x != '0) && !ovf_x_w &&
                   ((dist_x_w == '0) || (dist_x_w[CW-1] == in_q.velocity_x[31]));
    ctx_w.face_y = face_y_w;
    ctx_w.face_x = face_x_w;
    ctx_w.left   = left_w;
    ctx_w.right  = right_w;
    ctx_w.bottom = bottom_w;
    ctx_w.top    = top_w;
    ctx_w.sx     = in_q.start_x;
    ctx_w.sy     = in_q.start_y;
    ctx_w.vx     = in_q.velocity_x;
    ctx_w.vy     = in_q.velocity_y;
    ctx_w.best   = in_q.best_time_in;

    dy_w.rem = {14'd0, mag_y_w[33:16]};
    dy_w.num = {mag_y_w[15:0], 16'd0};
    dy_w.den = den_y_w;
    dy_w.quo = '0;
    dx_w.rem = {14'd0, mag_x_w[33:16]};
    dx_w.num = {mag_x_w[15:0], 16'd0};
    dx_w.den = den_x_w;
    dx_w.quo = '0;
  end

  swbh_pkg::ctx_t ctx_q [0:32];
  swbh_pkg::div_t dy_q  [0:32];
  swbh_pkg::div_t dx_q  [0:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_q[0] <= ctx_w;
      dy_q[0]  <= dy_w;
      dx_q[0]  <= dx_w;
    end
  end

  for (genvar k = 0; k < 32; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (en) begin
        ctx_q[k+1] <= ctx_q[k];
        dy_q[k+1]  <= div_step(dy_q[k]);
        dx_q[k+1]  <= div_step(dx_q[k]);
      end
    end
  end

  swbh_pkg::ctx_t     ctx_m_q;
  logic [31:0]        qy_m_q, qx_m_q;
  logic signed [63:0] py_m_q, px_m_q;
  logic signed [64:0] py_w, px_w;

  assign py_w = $signed({1'b0, dy_q[32].quo}) * ctx_q[32].vx;
  assign px_w = $signed({1'b0, dx_q[32].quo}) * ctx_q[32].vy;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_m_q <= ctx_q[32];
      qy_m_q  <= dy_q[32].quo;
      qx_m_q  <= dx_q[32].quo;
      py_m_q  <= py_w[63:0];
      px_m_q  <= px_w[63:0];
    end
  end

  logic signed [48:0]   cr_y_w, cr_x_w;
  swbh_pkg::ctx_t       ctx_c_q;
  logic [31:0]          qy_c_q, qx_c_q;
  logic signed [CW-1:0] cr_y_q, cr_x_q;
  logic                 in_y_q, in_x_q;

  assign cr_y_w = 49'(ctx_m_q.sx) + 49'($signed(py_m_q[63:16]));
  assign cr_x_w = 49'(ctx_m_q.sy) + 49'($signed(px_m_q[63:16]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_c_q <= ctx_m_q;
      qy_c_q  <= qy_m_q;
      qx_c_q  <= qx_m_q;
      cr_y_q  <= cr_y_w[CW-1:0];
      cr_x_q  <= cr_x_w[CW-1:0];
      in_y_q  <= (cr_y_w >= 49'(ctx_m_q.left)) && (cr_y_w <= 49'(ctx_m_q.right));
      in_x_q  <= (cr_x_w >= 49'(ctx_m_q.bottom)) && (cr_x_w <= 49'(ctx_m_q.top));
    end
  end

  logic                 hit_y_w, hit_x_w;
  logic [31:0]          best1_w;
  logic signed [CW-1:0] px_sel_w, py_sel_w;
  swbh_pkg::out_t       out_w;

  always_comb begin
    hit_y_w  = ctx_c_q.ok_y && (qy_c_q < ctx_c_q.best) && in_y_q;
    best1_w  = hit_y_w ? qy_c_q : ctx_c_q.best;
    hit_x_w  = ctx_c_q.ok_x && (qx_c_q < best1_w) && in_x_q;
    px_sel_w = hit_x_w ? ctx_c_q.face_x : cr_y_q;
    py_sel_w = hit_x_w ? cr_x_q : ctx_c_q.face_y;

    out_w.hit = hit_y_w || hit_x_w;
    if (hit_x_w) begin
      out_w.side          = ctx_c_q.vx[31] ? swbh_pkg::SIDE_RIGHT : swbh_pkg::SIDE_LEFT;
      out_w.best_time_out = qx_c_q;
    end else if (hit_y_w) begin
      out_w.side          = ctx_c_q.vy[31] ? swbh_pkg::SIDE_TOP : swbh_pkg::SIDE_BOTTOM;
      out_w.best_time_out = qy_c_q;
    end else begin
      out_w.side          = swbh_pkg::SIDE_NONE;
      out_w.best_time_out = ctx_c_q.best;
    end
    out_w.contact_x = out_w.hit ? $signed(clamp32(px_sel_w)) : '0;
    out_w.contact_y = out_w.hit ? $signed(clamp32(py_sel_w)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= out_w;
    end
  end

endmodule
